// File: sv/fixtok_pkg.sv
// Shared types, constants and byte-classification functions for the FIX tag=value tokenizer.
package fixtok_pkg;

  localparam logic [7:0] MAX_TAG_LEN   = 8'd64;
  localparam logic [7:0] MAX_VALUE_LEN = 8'd255;

  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;
  localparam int CFG_ADDR_W = 3;

  localparam logic CFG_REG_SWAP = 1'b0;

  typedef enum logic [2:0] {
    KIND_TAG       = 3'd0,
    KIND_EQUALS    = 3'd1,
    KIND_VALUE     = 3'd2,
    KIND_FIELD_END = 3'd3,
    KIND_STOP      = 3'd4,
    KIND_EMPTY     = 3'd5,
    KIND_OVERFLOW  = 3'd6,
    KIND_END       = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    PH_TAG     = 2'd0,
    PH_VALUE   = 2'd1,
    PH_AFTER   = 2'd2,
    PH_STOPPED = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    kind_t       kind;
    logic [15:0] field_index;
    logic [7:0]  field_pos;
    logic [15:0] record_pos;
    logic [7:0]  checksum;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    kind_t       kind;
    logic [7:0]  field_pos;
    phase_t      phase;
    logic [7:0]  part_len;
    logic [15:0] fields_done;
    logic [7:0]  sum;
  } plain_t;

  typedef struct packed {
    logic held;
    logic at_start;
  } core_status_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Handles one tag or value byte and returns the result and the updated parse state.
  function automatic plain_t plain_byte(input logic        is_tag,
                                        input logic [7:0]  part_len,
                                        input logic [7:0]  b,
                                        input logic [7:0]  swap,
                                        input logic [15:0] fields_done,
                                        input logic [7:0]  sum);
    plain_t     p;
    logic [7:0] v;
    p.byte_out    = b;
    p.kind        = KIND_TAG;
    p.field_pos   = part_len;
    p.phase       = is_tag ? PH_TAG : PH_VALUE;
    p.part_len    = part_len;
    p.fields_done = fields_done;
    p.sum         = sum;
    v = (b == swap) ? CH_SOH : b;
    if (is_tag) begin
      if (b == CH_EQ) begin
        p.kind     = KIND_EQUALS;
        p.phase    = PH_VALUE;
        p.part_len = 8'd0;
      end else if (part_len >= MAX_TAG_LEN) begin
        p.kind = KIND_OVERFLOW;
      end else begin
        p.kind     = KIND_TAG;
        p.part_len = part_len + 8'd1;
      end
    end else begin
      p.byte_out = v;
      p.sum      = sum + v;
      if (v == CH_SOH) begin
        p.fields_done = sat_inc16(fields_done);
        p.kind        = KIND_FIELD_END;
        p.part_len    = 8'd0;
        p.phase       = PH_AFTER;
      end else if (part_len >= MAX_VALUE_LEN) begin
        p.kind = KIND_OVERFLOW;
      end else begin
        p.kind     = KIND_VALUE;
        p.part_len = part_len + 8'd1;
      end
    end
    return p;
  endfunction

endpackage

// File: sv/fix_tag_value_tokenizer.sv
// Top level of the FIX tag=value tokenizer: stream ports, configuration port and checks.
//
// The block takes a FIX record one byte per request and classifies every byte as a tag
// byte, '=', value byte, field end (SOH), stop, empty record, overflow byte or record end,
// with the running field count, position inside the tag or value, record offset and a
// modulo-256 checksum over value bytes and SOH. A byte equal to the swap character (APB
// register at byte address 0, reset 0) is turned into SOH inside values. Each input byte
// is parsed in the cycle it is accepted and its results are written into a four-entry
// result queue; if it was empty, the first result is offered on the output in the next
// cycle. A byte gives zero, one or two results: a '<' directly after a field end is held
// back and gives nothing until the next byte decides between a stop and a released tag
// byte, in which case two results come out. The input accepts a byte in every cycle while
// the queue holds at most two results, so a stream of single-result bytes flows at one
// byte per cycle when the output is drained every cycle; the output port moves one result
// per cycle, which sets the pace whenever two-result bytes arrive back to back. in_tlast
// ends the record, and the parse state returns to its reset value right after that byte.
module fix_tag_value_tokenizer import fixtok_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] byte_in
  input  logic                  in_tlast,   // end_of_record
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata,  // [7:0] byte_out, [23:8] field_index,
                                            // [31:24] field_pos, [47:32] record_pos,
                                            // [55:48] checksum
  output logic [2:0]            out_tuser,  // [2:0] kind
  output logic                  out_tlast,  // last result of the input byte
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic             in_accept;
  logic [7:0]       swap_char;
  res_t             res0;
  res_t             res1;
  logic [1:0]       res_cnt;
  logic [1:0]       push_cnt;
  core_status_t     core_st;
  res_t             head;
  logic [CNT_W-1:0] fifo_cnt;
  logic             pop;

  // Room for the worst case of two results must exist before a byte is taken.
  assign in_tready = (fifo_cnt <= CNT_W'(FIFO_DEPTH - 2));
  assign in_accept = in_tvalid && in_tready;
  assign push_cnt  = in_accept ? res_cnt : 2'd0;
  assign pop       = out_tvalid && out_tready;
  assign pready    = 1'b1;

  fixtok_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .swap_char (swap_char)
  );

  fixtok_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .in_byte   (in_tdata),
    .in_eor    (in_tlast),
    .swap_char (swap_char),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt),
    .status    (core_st)
  );

  fixtok_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .res0     (res0),
    .res1     (res1),
    .pop      (pop),
    .head     (head),
    .count    (fifo_cnt)
  );

  assign out_tvalid = (fifo_cnt != '0);
  assign out_tdata  = {head.checksum, head.record_pos, head.field_pos,
                       head.field_index, head.byte_out};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

`ifndef SYNTHESIS
  // The result queue must never be pushed past its depth.
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // The byte that ends a record leaves the parser at the start of a new record.
  a_eor_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (core_st.at_start && !core_st.held))
    else $error("parser not cleared after record end");

  // An empty-record result carries only the byte; every counter field is zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_EMPTY)) |-> (out_tdata[55:8] == 48'd0))
    else $error("empty record result has nonzero counters");
`endif

endmodule

// File: sv/fixtok_cfg.sv
// Configuration register block holding the swap character.
module fixtok_cfg import fixtok_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic [7:0]            swap_char
);

  logic [7:0] swap_r;
  logic [7:0] swap_nxt;
  logic       sel_swap;

  assign sel_swap = (paddr[CFG_ADDR_W-1] == CFG_REG_SWAP);

  always_comb begin
    swap_nxt = swap_r;
    if (psel && penable && pwrite && sel_swap) begin
      swap_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 8'd0;
    end else begin
      swap_r <= swap_nxt;
    end
  end

  assign prdata    = sel_swap ? {24'd0, swap_r} : 32'd0;
  assign swap_char = swap_r;

endmodule

// File: sv/fixtok_core.sv
// Parse state and per-byte classification; produces up to two results per byte.
module fixtok_core import fixtok_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [7:0]   in_byte,
  input  logic         in_eor,
  input  logic [7:0]   swap_char,
  output res_t         res0,
  output res_t         res1,
  output logic [1:0]   res_cnt,
  output core_status_t status
);

  phase_t      phase_r, phase_nxt;
  logic        held_r, held_nxt;
  logic [7:0]  plen_r, plen_nxt;
  logic [15:0] fdone_r, fdone_nxt;
  logic [15:0] boff_r, boff_nxt;
  logic [7:0]  sum_r, sum_nxt;

  plain_t      pa;
  plain_t      pb;
  logic [15:0] boff1;
  logic [15:0] boff2;
  logic        is_empty;

  assign pa    = plain_byte(phase_r != PH_VALUE, plen_r, in_byte, swap_char, fdone_r, sum_r);
  // After a released '<' the new byte is a tag byte at position one.
  assign pb    = plain_byte(1'b1, 8'd1, in_byte, swap_char, fdone_r, sum_r);
  assign boff1 = sat_inc16(boff_r);
  assign boff2 = sat_inc16(boff1);

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    plen_nxt  = plen_r;
    fdone_nxt = fdone_r;
    boff_nxt  = boff_r;
    sum_nxt   = sum_r;
    res0      = '0;
    res1      = '0;
    res_cnt   = 2'd0;
    is_empty  = 1'b0;

    if (in_eor && (boff_r == 16'd0) && !held_r) begin
      is_empty = 1'b1;
      res0 = '{byte_out: in_byte, kind: KIND_EMPTY, field_index: 16'd0, field_pos: 8'd0,
               record_pos: 16'd0, checksum: 8'd0, last: 1'b1};
      res_cnt = 2'd1;
    end else if (phase_r == PH_STOPPED) begin
      if (in_eor) begin
        res0 = '{byte_out: in_byte, kind: KIND_END, field_index: fdone_r, field_pos: 8'd0,
                 record_pos: boff_r, checksum: sum_r, last: 1'b0};
        res_cnt = 2'd1;
      end
      boff_nxt = boff1;
    end else if ((phase_r == PH_AFTER) && held_r) begin
      held_nxt = 1'b0;
      if (in_byte == CH_SLASH) begin
        res0 = '{byte_out: in_byte, kind: KIND_STOP, field_index: fdone_r, field_pos: 8'd0,
                 record_pos: boff_r, checksum: sum_r, last: 1'b0};
        res_cnt   = 2'd1;
        boff_nxt  = boff2;
        phase_nxt = PH_STOPPED;
      end else begin
        res0 = '{byte_out: CH_LT, kind: KIND_TAG, field_index: fdone_r, field_pos: 8'd0,
                 record_pos: boff_r, checksum: sum_r, last: 1'b0};
        res1 = '{byte_out: pb.byte_out, kind: pb.kind, field_index: pb.fields_done,
                 field_pos: pb.field_pos, record_pos: boff1, checksum: pb.sum, last: 1'b0};
        res_cnt   = 2'd2;
        phase_nxt = pb.phase;
        plen_nxt  = pb.part_len;
        fdone_nxt = pb.fields_done;
        sum_nxt   = pb.sum;
        boff_nxt  = boff2;
      end
    end else if ((phase_r == PH_AFTER) && (in_byte == CH_LT) && !in_eor) begin
      held_nxt = 1'b1;
    end else begin
      res0 = '{byte_out: pa.byte_out, kind: pa.kind, field_index: pa.fields_done,
               field_pos: pa.field_pos, record_pos: boff_r, checksum: pa.sum, last: 1'b0};
      res_cnt   = 2'd1;
      phase_nxt = pa.phase;
      plen_nxt  = pa.part_len;
      fdone_nxt = pa.fields_done;
      sum_nxt   = pa.sum;
      boff_nxt  = boff1;
    end

    if (!is_empty) begin
      if (res_cnt == 2'd1) begin
        res0.last = 1'b1;
        if (in_eor) begin
          res0.kind = KIND_END;
        end
      end else if (res_cnt == 2'd2) begin
        res1.last = 1'b1;
        if (in_eor) begin
          res1.kind = KIND_END;
        end
      end
    end

    if (in_eor) begin
      phase_nxt = PH_TAG;
      held_nxt  = 1'b0;
      plen_nxt  = 8'd0;
      fdone_nxt = 16'd0;
      boff_nxt  = 16'd0;
      sum_nxt   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      held_r  <= 1'b0;
      plen_r  <= 8'd0;
      fdone_r <= 16'd0;
      boff_r  <= 16'd0;
      sum_r   <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      plen_r  <= plen_nxt;
      fdone_r <= fdone_nxt;
      boff_r  <= boff_nxt;
      sum_r   <= sum_nxt;
    end
  end

  assign status.held     = held_r;
  assign status.at_start = (boff_r == 16'd0);

endmodule

// File: sv/fixtok_fifo.sv
// Small result queue that takes up to two results per cycle and hands out one.
module fixtok_fifo import fixtok_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  res_t             res0,
  input  res_t             res1,
  input  logic             pop,
  output res_t             head,
  output logic [CNT_W-1:0] count
);

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r + PTR_W'(push_cnt);
    rptr_nxt = rptr_r + PTR_W'(pop);
    cnt_nxt  = cnt_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wptr_r] <= res0;
    end
    if (push_cnt == 2'd2) begin
      mem[wptr_r + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign head  = mem[rptr_r];
  assign count = cnt_r;

endmodule
